// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the frame encoder.
// Needs nothing else; the simulation form is left out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_SYNC(lbl, ck, rstn, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) prop) else $error(msg);
`define ASSERT_NEVER(lbl, ck, rstn, cond, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_SYNC(lbl, ck, rstn, prop, msg)
`define ASSERT_NEVER(lbl, ck, rstn, cond, msg)
`endif
`endif

// ===== rtl/fsc_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants and types of the stuffing frame encoder.
// Used by the front, queue, back and top-level modules.
package fsc_pkg;

  localparam logic [7:0] FSC_FLAG       = 8'h7E;
  localparam logic [7:0] FSC_ESC        = 8'h7F;
  localparam logic [7:0] FSC_ESC_FLAG   = 8'h80;
  localparam logic [7:0] FSC_CHECK_SEED = 8'h55;

  localparam int FSC_QDEPTH = 4;
  localparam int FSC_QAW    = $clog2(FSC_QDEPTH);

  // One classified payload item, as the back end plays it out.
  typedef struct packed {
    logic       open;     // a new frame starts: send the opening flag first
    logic [7:0] data;
    logic       data_esc; // data is a flag or escape byte
    logic       last;
    logic [7:0] check;    // valid when last is set
    logic       chk_esc;
  } fsc_desc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fsc_qstat_t;

  typedef enum logic [2:0] {
    PH_HEAD,
    PH_DATA,
    PH_DATA2,
    PH_CHK,
    PH_CHK2,
    PH_CLOSE
  } fsc_phase_t;

  function automatic logic fsc_needs_esc(input logic [7:0] b);
    return (b == FSC_FLAG) || (b == FSC_ESC);
  endfunction

endpackage

// ===== rtl/fsc_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts payload items, tracks frame state and the running sum,
// and classifies each item into a descriptor for the queue. Uses fsc_pkg.
module fsc_front import fsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_frame
  input  fsc_qstat_t q_stat,
  output logic       push,
  output fsc_desc_t  push_desc
);

  logic       inside_r, inside_nxt;
  logic [7:0] sum_r, sum_nxt;
  logic [7:0] sum_plus;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;
  assign sum_plus  = sum_r + in_tdata;

  always_comb begin
    push_desc.open     = !inside_r;
    push_desc.data     = in_tdata;
    push_desc.data_esc = fsc_needs_esc(in_tdata);
    push_desc.last     = in_tlast;
    push_desc.check    = FSC_CHECK_SEED - sum_plus;
    push_desc.chk_esc  = fsc_needs_esc(push_desc.check);
    inside_nxt = inside_r;
    sum_nxt    = sum_r;
    if (push) begin
      inside_nxt = !in_tlast;
      sum_nxt    = in_tlast ? 8'h00 : sum_plus;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      sum_r    <= 8'h00;
    end else begin
      inside_r <= inside_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

// ===== rtl/fsc_fifo.sv =====
`timescale 1ns / 1ps
// Short descriptor queue between the front and back ends.
// Uses fsc_pkg for the descriptor type and depth.
module fsc_fifo import fsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  fsc_desc_t  push_desc,
  input  logic       pop,
  output fsc_desc_t  head,
  output fsc_qstat_t stat
);

  fsc_desc_t            mem_r [FSC_QDEPTH];
  logic [FSC_QAW-1:0]   wptr_r, wptr_nxt;
  logic [FSC_QAW-1:0]   rptr_r, rptr_nxt;
  logic [FSC_QAW:0]     cnt_r, cnt_nxt;

  assign head       = mem_r[rptr_r];
  assign stat.full  = (cnt_r == FSC_QAW'(0) + (FSC_QAW+1)'(FSC_QDEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_desc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== rtl/fsc_back.sv =====
`timescale 1ns / 1ps
// Back end: plays out the queue head one line byte per cycle, while not stalled,
// into the output register, inserting flags, escapes and the check byte. Uses fsc_pkg.
module fsc_back import fsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  fsc_desc_t  head,
  input  fsc_qstat_t q_stat,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] line_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // frame_closed
);

  fsc_phase_t ph_r, ph_nxt, cur;
  logic       step;
  logic       fin;
  logic [7:0] byte_c;
  logic       closed_c;
  logic       oval_r, oval_nxt;
  logic [7:0] obyte_r;
  logic       olast_r, oclosed_r;

  // The output register is free when empty or being drained this cycle.
  assign step = !q_stat.empty && (!oval_r || out_tready);
  assign pop  = step && fin;

  always_comb begin
    // A head entry that does not open a frame starts at its data byte.
    cur      = (ph_r == PH_HEAD && !head.open) ? PH_DATA : ph_r;
    byte_c   = FSC_FLAG;
    closed_c = 1'b0;
    fin      = 1'b0;
    ph_nxt   = ph_r;
    case (cur)
      PH_HEAD: begin
        byte_c = FSC_FLAG;
        ph_nxt = PH_DATA;
      end
      PH_DATA: begin
        byte_c = head.data_esc ? FSC_ESC : head.data;
        if (head.data_esc) begin
          ph_nxt = PH_DATA2;
        end else if (head.last) begin
          ph_nxt = PH_CHK;
        end else begin
          fin = 1'b1;
        end
      end
      PH_DATA2: begin
        // Flag maps to 0x80 and escape to 0x81: they differ only in bit 0.
        byte_c = FSC_ESC_FLAG | {7'd0, head.data[0]};
        if (head.last) begin
          ph_nxt = PH_CHK;
        end else begin
          fin = 1'b1;
        end
      end
      PH_CHK: begin
        byte_c = head.chk_esc ? FSC_ESC : head.check;
        ph_nxt = head.chk_esc ? PH_CHK2 : PH_CLOSE;
      end
      PH_CHK2: begin
        byte_c = FSC_ESC_FLAG | {7'd0, head.check[0]};
        ph_nxt = PH_CLOSE;
      end
      PH_CLOSE: begin
        byte_c   = FSC_FLAG;
        closed_c = 1'b1;
        fin      = 1'b1;
      end
      default: begin
        fin = 1'b1;
      end
    endcase
    if (fin) begin
      ph_nxt = PH_HEAD;
    end
    if (!step) begin
      ph_nxt = ph_r;
    end
    oval_nxt = step || (oval_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_HEAD;
      oval_r <= 1'b0;
    end else begin
      ph_r   <= ph_nxt;
      oval_r <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      obyte_r   <= byte_c;
      olast_r   <= fin;
      oclosed_r <= closed_c;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tdata  = obyte_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = oclosed_r;

endmodule

// ===== rtl/frame_stuff_checksum_encoder_unit.sv =====
`timescale 1ns / 1ps
// Channel  Dir  tdata          tlast         tuser
// in_      in   data_byte[7:0] end_of_frame  -
// out_     out  line_byte[7:0] run_last      frame_closed
//
// The back end sends one line byte per cycle when not stalled; an item causes
// one to six line bytes (flag, escapes, check byte, closing flag).
// A four-entry descriptor queue lets the input run ahead while the output stalls.
// With the queue and output register empty, an accepted item is written into the queue
// and the first line byte it causes is then registered in the output register and presented.
// Reset is synchronous and clears frame state, sum, queue and output valid.
// Top level of the stuffing frame encoder; uses fsc_pkg, fsc_front, fsc_fifo,
// fsc_back and assert_macros.svh.
`include "assert_macros.svh"
module frame_stuff_checksum_encoder_unit import fsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // end_of_frame
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] line_byte
  output logic       out_tlast,  // run_last
  output logic       out_tuser   // frame_closed
);

  fsc_qstat_t q_stat;
  fsc_desc_t  push_desc, head;
  logic       push, pop;

  fsc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_stat    (q_stat),
    .push      (push),
    .push_desc (push_desc)
  );

  fsc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (push_desc),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  fsc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .q_stat     (q_stat),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `ASSERT_SYNC(a_close_last, clk, rst_n, out_tvalid && out_tuser |-> out_tlast, "close not last")
  `ASSERT_NEVER(a_queue_state, clk, rst_n, q_stat.full && q_stat.empty, "queue full and empty")
  `ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && q_stat.empty, "pop from empty queue")
  `ASSERT_SYNC(a_pop_shows, clk, rst_n, pop |=> out_tvalid && out_tlast, "missing run_last")

endmodule

// ===== test/frame_stuff_checksum_encoder_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the stuffing frame encoder: a directed table and random frames
// are checked against typed line bytes or an in-bench model of framing, stuffing and the
// check byte. Depends only on fsc_pkg and frame_stuff_checksum_encoder_unit.
module frame_stuff_checksum_encoder_unit_test;
  import fsc_pkg::*;

  // The escape code for a payload escape byte has no package constant.
  localparam logic [7:0] ESC_ESC_CODE = 8'h81;
  localparam int         CLK_HALF     = 6;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       run_last;
    logic       frame_closed;
  } line_byte_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eof;
    logic [2:0]  typed_n;
    logic [47:0] typed_bytes;  // typed line bytes, first one most significant
  } table_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;    // [7:0] data_byte
  logic       in_tlast = 1'b0;     // end_of_frame
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;           // [7:0] line_byte
  logic       out_tlast;           // run_last
  logic       out_tuser;           // frame_closed

  frame_stuff_checksum_encoder_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Encoder model state and its output.
  logic        model_in_frame = 1'b0;
  logic [7:0]  model_frame_sum = 8'h00;
  line_byte_t  item_line_bytes[$];
  line_byte_t  pending_line_bytes[$];
  table_row_t  directed_rows[$];

  int  errors = 0;
  bit  idle_on = 1'b1;
  bit  long_hold_req = 1'b0;

  function void put_line_byte(input logic [7:0] b, input logic closed);
    line_byte_t lb;
    lb.line_byte    = b;
    lb.run_last     = 1'b0;
    lb.frame_closed = closed;
    item_line_bytes.push_back(lb);
  endfunction

  function void put_stuffed(input logic [7:0] b);
    if (b == FSC_FLAG) begin
      put_line_byte(FSC_ESC, 1'b0);
      put_line_byte(FSC_ESC_FLAG, 1'b0);
    end else if (b == FSC_ESC) begin
      put_line_byte(FSC_ESC, 1'b0);
      put_line_byte(ESC_ESC_CODE, 1'b0);
    end else begin
      put_line_byte(b, 1'b0);
    end
  endfunction

  // Line bytes caused by one payload byte; run_last is set when they are queued.
  function void encode_payload_byte(input logic [7:0] b, input logic eof);
    item_line_bytes.delete();
    if (!model_in_frame) begin
      put_line_byte(FSC_FLAG, 1'b0);
      model_in_frame = 1'b1;
    end
    put_stuffed(b);
    model_frame_sum = model_frame_sum + b;
    if (eof) begin
      put_stuffed(FSC_CHECK_SEED - model_frame_sum);
      put_line_byte(FSC_FLAG, 1'b1);
      model_in_frame  = 1'b0;
      model_frame_sum = 8'h00;
    end
  endfunction

  function void add_row(input logic [7:0] data, input logic eof, input logic [2:0] typed_n,
                        input logic [47:0] typed_bytes);
    table_row_t r;
    r.data        = data;
    r.eof         = eof;
    r.typed_n     = typed_n;
    r.typed_bytes = typed_bytes;
    directed_rows.push_back(r);
  endfunction

  // Offer one item, wait for it to be taken and queue what it should cause.
  // With typed_n nonzero the typed bytes replace the model's prediction.
  task automatic send_payload(input logic [7:0] b, input logic eof, input int typed_n,
                              input logic [47:0] typed_bytes);
    line_byte_t  lb;
    logic [47:0] shifted;
    int          n;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eof;
    do @(posedge clk); while (in_tready !== 1'b1);
    encode_payload_byte(b, eof);
    if (typed_n != 0) begin
      item_line_bytes.delete();
      for (int i = 0; i < typed_n; i++) begin
        shifted = typed_bytes >> (8 * (typed_n - 1 - i));
        put_line_byte(shifted[7:0], eof && (i == typed_n - 1));
      end
    end
    n = item_line_bytes.size();
    for (int i = 0; i < n; i++) begin
      lb = item_line_bytes[i];
      lb.run_last = (i == n - 1);
      pending_line_bytes.push_back(lb);
    end
  endtask

  task automatic drain_pending;
    in_tvalid <= 1'b0;
    while (pending_line_bytes.size() != 0) @(posedge clk);
  endtask

  function logic [7:0] pick_payload_byte;
    case ($urandom_range(0, 9))
      0:       pick_payload_byte = FSC_FLAG;
      1:       pick_payload_byte = FSC_ESC;
      2:       pick_payload_byte = FSC_ESC_FLAG;
      3:       pick_payload_byte = ESC_ESC_CODE;
      4:       pick_payload_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: pick_payload_byte = 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Line side: check each taken byte, then choose the next tready.
  initial begin : line_sink
    int         stall_left;
    line_byte_t want;
    stall_left = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_tvalid === 1'b1 && out_tready === 1'b1) begin
        if (pending_line_bytes.size() == 0) begin
          errors++;
          $display("%0t: line byte with nothing expected: expected none, actual %h",
                   $time, out_tdata);
        end else begin
          want = pending_line_bytes.pop_front();
          if (out_tdata !== want.line_byte) begin
            errors++;
            $display("%0t: line_byte expected %h actual %h", $time, want.line_byte, out_tdata);
          end
          if (out_tlast !== want.run_last) begin
            errors++;
            $display("%0t: run_last expected %b actual %b", $time, want.run_last, out_tlast);
          end
          if (out_tuser !== want.frame_closed) begin
            errors++;
            $display("%0t: frame_closed expected %b actual %b", $time, want.frame_closed,
                     out_tuser);
          end
        end
      end
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 100;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 6);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin : payload_source
    int          sent;
    int          frame_len;
    int          wait_cycles;
    logic [7:0]  b;
    logic        eof;
    table_row_t  r;

    // Known line bytes: the opening flag after reset, stuffing of both special bytes,
    // check bytes that need escaping, and a two-item frame whose last byte and check are escaped.
    add_row(8'h00, 1'b0, 3'd2, 48'h7E00);
    add_row(8'hFF, 1'b0, 3'd1, 48'hFF);
    add_row(8'h7E, 1'b0, 3'd2, 48'h7F80);
    add_row(8'h7F, 1'b1, 3'd4, 48'h7F81597E);
    add_row(8'h00, 1'b1, 3'd4, 48'h7E00557E);
    add_row(8'hD7, 1'b1, 3'd5, 48'h7ED77F807E);
    add_row(8'hD6, 1'b1, 3'd5, 48'h7ED67F817E);
    add_row(8'h59, 1'b0, 3'd2, 48'h7E59);
    add_row(8'h7E, 1'b1, 3'd5, 48'h7F807F807E);
    add_row(8'hFF, 1'b1, 3'd4, 48'h7EFF567E);
    add_row(8'h55, 1'b1, 3'd4, 48'h7E55007E);
    // The rest are predicted by the model.
    add_row(8'h80, 1'b0, 3'd0, 48'h0);
    add_row(8'h81, 1'b0, 3'd0, 48'h0);
    add_row(8'h7F, 1'b0, 3'd0, 48'h0);
    add_row(8'h7E, 1'b0, 3'd0, 48'h0);
    add_row(8'hAA, 1'b0, 3'd0, 48'h0);
    add_row(8'hFF, 1'b0, 3'd0, 48'h0);
    add_row(8'hFF, 1'b0, 3'd0, 48'h0);
    add_row(8'h01, 1'b1, 3'd0, 48'h0);
    add_row(8'h7F, 1'b1, 3'd0, 48'h0);
    add_row(8'h80, 1'b0, 3'd0, 48'h0);
    add_row(8'h81, 1'b1, 3'd0, 48'h0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      r = directed_rows[i];
      send_payload(r.data, r.eof, int'(r.typed_n), r.typed_bytes);
    end
    drain_pending();

    sent = 0;
    while (sent < 250) begin
      frame_len = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
      for (int k = 0; k < frame_len; k++) begin
        eof = (k == frame_len - 1);
        b = pick_payload_byte();
        // Steer some check bytes onto the flag or escape value.
        if (eof && $urandom_range(0, 3) == 0) begin
          b = FSC_CHECK_SEED - model_frame_sum - ($urandom_range(0, 1) ? FSC_FLAG : FSC_ESC);
        end
        if (sent == 70) begin
          long_hold_req = 1'b1;
        end
        if (sent == 150) begin
          drain_pending();
          repeat (5) @(posedge clk);
        end
        idle_on = !((sent >= 110 && sent < 130) || sent >= 210);
        send_payload(b, eof, 0, 48'h0);
        sent++;
      end
    end
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (pending_line_bytes.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (20) @(posedge clk);
    if (pending_line_bytes.size() != 0) begin
      errors++;
      $display("%0t: line bytes never sent: expected 0 left, actual %0d left", $time,
               pending_line_bytes.size());
    end
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(2 * CLK_HALF * 400000);
    $display("TEST FAILED");
    $finish;
  end

endmodule
